// ----- design/sfr_pkg.sv -----
// Shared types, register indexes and constants for the serial frame receiver.
`default_nettype none
package sfr_pkg;

  localparam logic [7:0]  START_MARK   = 8'h3C;
  localparam logic [7:0]  HS_OPEN_CODE = 8'd1;
  localparam logic [7:0]  HS_ALT_CODE  = 8'd22;
  localparam logic [15:0] HS_OPEN_MIN  = 16'd8;
  localparam logic [15:0] HS_ALT_MIN   = 16'd2;

  localparam logic [15:0] TIMEOUT_RST  = 16'd2000;
  localparam logic [23:0] LEASE_RST    = 24'd300000;
  localparam logic [15:0] MAX_LEN_RST  = 16'd172;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED     = 3'd0,
    REG_LINK_PROBE  = 3'd1,
    REG_TIMEOUT     = 3'd2,
    REG_LEASE       = 3'd3,
    REG_MAX_LEN     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HDR  = 2'd1,
    PH_LEN1 = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  // Classified input item, as queued between front and back.
  typedef struct packed {
    logic       is_tick;
    logic       link;
    logic [7:0] data;
    logic       is_start;
    logic       is_hs_open;
    logic       is_hs_alt;
  } item_t;

  function automatic logic [31:0] gen_advance(input logic [31:0] g);
    logic [31:0] n;
    n = g + 32'd1;
    return (n == 32'd0) ? 32'd1 : n;
  endfunction

endpackage
`default_nettype wire

// ----- design/serial_frame_receiver_session.sv -----
// An accepted transaction is queued, then its result is registered and driven on out_*.
// Throughput: one item per cycle; one queued item retires each cycle the result register
// is free or being taken with cfg_valid low, and a two-entry queue decouples the input.
// Reset (rst_n low, synchronous): parser idle, no session, generation and tick count
// zero, registers at their defaults, queue and result register empty.
`default_nettype none
module serial_frame_receiver_session
  import sfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] rx_byte, [8] link_up, rest zero
  input  wire logic                  in_tuser,   // [0] req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [7:0] payload_byte, [8] frame_aborted,
                                                 // [9] flush_tx_queue, [10] session_active,
                                                 // [42:11] session_generation, rest zero
  output logic                       out_tlast,  // last_byte
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_item;
  item_t q_head;

  sfr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  sfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire

// ----- design/sfr_front.sv -----
// Front end: takes input transactions and classifies them into queue items.
`default_nettype none
module sfr_front
  import sfr_pkg::*;
(
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,   // [7:0] rx_byte, [8] link_up, rest zero
  input  wire logic                 in_tuser,   // [0] req_type
  input  wire logic                 q_full,
  output logic                      q_push,
  output item_t                     q_item
);

  logic [7:0] rx;

  assign rx        = in_tdata[7:0];
  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

  always_comb begin
    q_item.is_tick    = in_tuser;
    q_item.link       = in_tdata[8];
    q_item.data       = rx;
    q_item.is_start   = (rx == START_MARK);
    q_item.is_hs_open = (rx == HS_OPEN_CODE);
    q_item.is_hs_alt  = (rx == HS_ALT_CODE);
  end

endmodule
`default_nettype wire

// ----- design/sfr_queue.sv -----
// Two-entry queue of classified items between front and back.
`default_nettype none
module sfr_queue
  import sfr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output logic       full,
  output logic       not_empty,
  output item_t      head
);

  item_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/sfr_back.sv -----
// Back end: configuration, frame parser, session tracking and result register.
`default_nettype none
module sfr_back
  import sfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  q_not_empty,
  input  wire item_t                 q_head,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  // configuration
  logic        enabled_r, enabled_nxt;
  logic        probe_r, probe_nxt;
  logic [15:0] timeout_r, timeout_nxt;
  logic [23:0] lease_r, lease_nxt;
  logic [15:0] max_len_r, max_len_nxt;

  // parser and session state
  phase_t      phase_r, phase_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] rcvd_r, rcvd_nxt;
  logic        passing_r, passing_nxt;
  logic        hs_r, hs_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic        open_r, open_nxt;
  logic [31:0] last_act_r, last_act_nxt;
  logic [31:0] gen_r, gen_nxt;

  // result register
  logic                  ovalid_r, ovalid_nxt;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic                  olast_r, olast_nxt;

  logic        cfg_wr;
  logic        link_drop;
  logic        timeout_hit;
  logic        first_byte;
  logic        hs_now;
  logic        passing_now;
  logic [15:0] rcvd_inc;
  logic        frame_end;
  logic        fresh_cur;
  logic        fresh_after;
  logic        emit_abort;
  logic        emit_byte;
  logic        flush;
  logic [31:0] tick_diff;
  logic [31:0] tick_inc;

  function automatic logic lease_fresh(input logic open, input logic probe,
                                       input logic link, input logic [23:0] lease,
                                       input logic [31:0] now, input logic [31:0] last);
    logic [31:0] d;
    d = now - last;
    if (!open) return 1'b0;
    if (probe) return link;
    if (lease == 24'd0) return 1'b1;
    return (d < {8'd0, lease});
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign q_pop     = q_not_empty & (~ovalid_r | out_tready) & ~cfg_wr;

  assign tick_inc    = tick_r + {31'd0, q_head.is_tick};
  assign tick_diff   = tick_inc - start_r;
  assign link_drop   = probe_r & ~q_head.link;
  assign timeout_hit = (phase_r != PH_IDLE) && (tick_diff >= {16'd0, timeout_r});
  assign first_byte  = (rcvd_r == 16'd0);
  assign hs_now      = first_byte ?
                       ((q_head.is_hs_open && len_r >= HS_OPEN_MIN) ||
                        (q_head.is_hs_alt && len_r >= HS_ALT_MIN)) : hs_r;
  assign passing_now = first_byte ? ((len_r <= max_len_r) && (open_r || hs_now)) : passing_r;
  assign rcvd_inc    = rcvd_r + 16'd1;
  assign frame_end   = ~(rcvd_inc < len_r);
  assign fresh_cur   = lease_fresh(open_r, probe_r, q_head.link, lease_r, tick_inc,
                                   last_act_r);

  // next state
  always_comb begin
    enabled_nxt  = enabled_r;
    probe_nxt    = probe_r;
    timeout_nxt  = timeout_r;
    lease_nxt    = lease_r;
    max_len_nxt  = max_len_r;
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    rcvd_nxt     = rcvd_r;
    passing_nxt  = passing_r;
    hs_nxt       = hs_r;
    start_nxt    = start_r;
    tick_nxt     = tick_r;
    open_nxt     = open_r;
    last_act_nxt = last_act_r;
    gen_nxt      = gen_r;
    if (cfg_wr) begin
      case (cfg_index)
        REG_ENABLED: begin
          enabled_nxt  = cfg_data[0];
          open_nxt     = 1'b0;
          last_act_nxt = 32'd0;
          phase_nxt    = PH_IDLE;
          len_nxt      = 16'd0;
          rcvd_nxt     = 16'd0;
          passing_nxt  = 1'b0;
          hs_nxt       = 1'b0;
          start_nxt    = 32'd0;
          if (open_r) gen_nxt = gen_advance(gen_r);
        end
        REG_LINK_PROBE: probe_nxt   = cfg_data[0];
        REG_TIMEOUT:    timeout_nxt = cfg_data[15:0];
        REG_LEASE:      lease_nxt   = cfg_data[23:0];
        REG_MAX_LEN:    max_len_nxt = cfg_data[15:0];
        default: ;
      endcase
    end else if (q_pop) begin
      tick_nxt = tick_inc;
      if (!enabled_r || link_drop) begin
        if (open_r || link_drop) begin
          open_nxt     = 1'b0;
          last_act_nxt = 32'd0;
          phase_nxt    = PH_IDLE;
          len_nxt      = 16'd0;
          rcvd_nxt     = 16'd0;
          passing_nxt  = 1'b0;
          hs_nxt       = 1'b0;
          start_nxt    = 32'd0;
          if (open_r) gen_nxt = gen_advance(gen_r);
        end
      end else if (q_head.is_tick) begin
        if (timeout_hit) begin
          phase_nxt   = PH_IDLE;
          len_nxt     = 16'd0;
          rcvd_nxt    = 16'd0;
          passing_nxt = 1'b0;
          hs_nxt      = 1'b0;
          start_nxt   = 32'd0;
        end
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (q_head.is_start) begin
              phase_nxt = PH_HDR;
              start_nxt = tick_inc;
            end
          end
          PH_HDR: begin
            len_nxt   = {8'd0, q_head.data};
            phase_nxt = PH_LEN1;
          end
          PH_LEN1: begin
            rcvd_nxt = 16'd0;
            if ({q_head.data, len_r[7:0]} != 16'd0) begin
              len_nxt   = {q_head.data, len_r[7:0]};
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt   = PH_IDLE;
              len_nxt     = 16'd0;
              passing_nxt = 1'b0;
              hs_nxt      = 1'b0;
              start_nxt   = 32'd0;
            end
          end
          PH_DATA: begin
            if (!frame_end) begin
              rcvd_nxt    = rcvd_inc;
              passing_nxt = passing_now;
              hs_nxt      = hs_now;
            end else begin
              phase_nxt   = PH_IDLE;
              len_nxt     = 16'd0;
              rcvd_nxt    = 16'd0;
              passing_nxt = 1'b0;
              hs_nxt      = 1'b0;
              start_nxt   = 32'd0;
              if (passing_now) begin
                if (!open_r && hs_now) begin
                  open_nxt = 1'b1;
                  gen_nxt  = gen_advance(gen_r);
                end else if (hs_now && !probe_r && !fresh_cur) begin
                  gen_nxt = gen_advance(gen_r);
                end
                if (open_r || hs_now) last_act_nxt = tick_inc;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign fresh_after = lease_fresh(open_nxt, probe_r, q_head.link, lease_r, tick_nxt,
                                   last_act_nxt);

  // result
  always_comb begin
    emit_abort = enabled_r & passing_r & (link_drop | (q_head.is_tick & timeout_hit));
    emit_byte  = enabled_r & ~link_drop & ~q_head.is_tick & (phase_r == PH_DATA) &
                 passing_now;
    flush      = emit_byte & frame_end & open_r & hs_now & ~probe_r & ~fresh_cur;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (q_pop) begin
      ovalid_nxt = emit_abort | emit_byte;
      odata_nxt  = {5'd0, gen_nxt, enabled_r & fresh_after, flush, emit_abort,
                    emit_byte ? q_head.data : 8'd0};
      olast_nxt  = emit_byte & frame_end;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      probe_r    <= 1'b0;
      timeout_r  <= TIMEOUT_RST;
      lease_r    <= LEASE_RST;
      max_len_r  <= MAX_LEN_RST;
      phase_r    <= PH_IDLE;
      len_r      <= 16'd0;
      rcvd_r     <= 16'd0;
      passing_r  <= 1'b0;
      hs_r       <= 1'b0;
      start_r    <= 32'd0;
      tick_r     <= 32'd0;
      open_r     <= 1'b0;
      last_act_r <= 32'd0;
      gen_r      <= 32'd0;
      ovalid_r   <= 1'b0;
    end else begin
      enabled_r  <= enabled_nxt;
      probe_r    <= probe_nxt;
      timeout_r  <= timeout_nxt;
      lease_r    <= lease_nxt;
      max_len_r  <= max_len_nxt;
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      rcvd_r     <= rcvd_nxt;
      passing_r  <= passing_nxt;
      hs_r       <= hs_nxt;
      start_r    <= start_nxt;
      tick_r     <= tick_nxt;
      open_r     <= open_nxt;
      last_act_r <= last_act_nxt;
      gen_r      <= gen_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the length-prefixed serial frame receiver with session tracking.
`timescale 1ns / 1ps
module tb_top;
  import sfr_pkg::*;

  localparam int ITEM_TARGET      = 1600;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int FIRST_UNUSED_REG = 5;
  localparam int LAST_REG_INDEX   = (1 << CFG_IDX_W) - 1;

  typedef enum int {
    CFG_SHORT_LEASE, CFG_PROBE_WIDE, CFG_TIGHT, CFG_OFF,
    CFG_SLOW, CFG_WIDE_LEN, CFG_PROBE_TIGHT, CFG_DIRECTED
  } cfg_profile_t;

  // Deframer/session predictor plus the queue of outputs it still owes.
  class deframer_scoreboard;
    typedef struct {
      logic [7:0]  payload;
      bit          last;
      bit          aborted;
      bit          flush;
      bit          active;
      logic [31:0] gen;
    } rx_result_t;

    rx_result_t  pending_outputs[$];
    int          errors, n_results, n_last, n_abort, n_flush;

    bit          en, probe;
    logic [15:0] tmo, maxlen;
    logic [23:0] lease;

    phase_t      rx_phase;
    logic [15:0] flen, brx;
    bit          passing, hs_frame, sess;
    logic [31:0] fstart, ticks, last_act, gen;

    function new();
      en = 0; probe = 0; tmo = TIMEOUT_RST; lease = LEASE_RST; maxlen = MAX_LEN_RST;
      ticks = 0; sess = 0; last_act = 0; gen = 0;
      errors = 0; n_results = 0; n_last = 0; n_abort = 0; n_flush = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      rx_phase = PH_IDLE; flen = 0; brx = 0; passing = 0; hs_frame = 0; fstart = 0;
    endfunction

    function void bump_gen();
      gen = gen + 32'd1;
      if (gen == 32'd0) gen = 32'd1;
    endfunction

    function void drop_session();
      bit had;
      had = sess;
      sess = 0;
      last_act = 0;
      clear_parser();
      if (had) bump_gen();
    endfunction

    function bit lease_ok(bit link);
      if (!sess) return 0;
      if (probe) return link;
      if (lease == 0) return 1;
      return (ticks - last_act) < {8'd0, lease};
    endfunction

    function void expect_output(logic [7:0] b, bit last, bit abrt, bit flush, bit link);
      rx_result_t r;
      r.payload = b;
      r.last    = last;
      r.aborted = abrt;
      r.flush   = flush;
      r.active  = en && lease_ok(link);
      r.gen     = gen;
      pending_outputs.push_back(r);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ENABLED: begin
          drop_session();
          en = d[0];
        end
        REG_LINK_PROBE: probe = d[0];
        REG_TIMEOUT:    tmo = d[15:0];
        REG_LEASE:      lease = d[23:0];
        REG_MAX_LEN:    maxlen = d[15:0];
        default: ;
      endcase
    endfunction

    function void predict_item(bit tick, logic [7:0] b, bit link);
      bit was_pass, hs_now, pass_now, hs_keep, flush;
      if (tick) ticks = ticks + 32'd1;
      was_pass = passing;
      if (!en) begin
        if (sess) drop_session();
        return;
      end
      if (probe && !link) begin
        drop_session();
        if (was_pass) expect_output(8'd0, 0, 1, 0, link);
        return;
      end
      if (tick) begin
        if (rx_phase != PH_IDLE && (ticks - fstart) >= {16'd0, tmo}) begin
          clear_parser();
          if (was_pass) expect_output(8'd0, 0, 1, 0, link);
        end
        return;
      end
      case (rx_phase)
        PH_IDLE: begin
          if (b == START_MARK) begin
            rx_phase = PH_HDR;
            fstart = ticks;
          end
          return;
        end
        PH_HDR: begin
          flen = {8'd0, b};
          rx_phase = PH_LEN1;
          return;
        end
        PH_LEN1: begin
          flen[15:8] = b;
          brx = 0;
          if (flen != 0) rx_phase = PH_DATA;
          else clear_parser();
          return;
        end
        default: ;
      endcase
      if (brx == 0) begin
        hs_now = (b == HS_OPEN_CODE && flen >= HS_OPEN_MIN) ||
                 (b == HS_ALT_CODE && flen >= HS_ALT_MIN);
        hs_frame = hs_now;
        passing = (flen <= maxlen) && (sess || hs_now);
      end
      brx = brx + 16'd1;
      if (brx < flen) begin
        if (passing) expect_output(b, 0, 0, 0, link);
        return;
      end
      pass_now = passing;
      hs_keep = hs_frame;
      flush = 0;
      clear_parser();
      if (!pass_now) return;
      if (!sess && hs_keep) begin
        sess = 1;
        bump_gen();
      end else if (hs_keep && !probe && !lease_ok(link)) begin
        flush = 1;
        bump_gen();
      end
      if (sess) last_act = ticks;
      expect_output(b, 1, 0, flush, link);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_output(logic [7:0] pb, logic lb, logic ab, logic fl, logic act,
                      logic [31:0] g);
      rx_result_t e;
      if (pending_outputs.size() == 0) begin
        report($sformatf("unexpected transaction, byte %02h last %b abort %b", pb, lb, ab));
        return;
      end
      e = pending_outputs.pop_front();
      n_results++;
      if (e.last) n_last++;
      if (e.aborted) n_abort++;
      if (e.flush) n_flush++;
      if (pb !== e.payload) report($sformatf("payload_byte %02h, want %02h", pb, e.payload));
      if (lb !== e.last) report($sformatf("last_byte %b, want %b", lb, e.last));
      if (ab !== e.aborted) report($sformatf("frame_aborted %b, want %b", ab, e.aborted));
      if (fl !== e.flush) report($sformatf("flush_tx_queue %b, want %b", fl, e.flush));
      if (act !== e.active) report($sformatf("session_active %b, want %b", act, e.active));
      if (g !== e.gen) report($sformatf("session_generation %0d, want %0d", g, e.gen));
    endtask
  endclass

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [7:0] rx_byte, [8] link_up, rest zero
  logic                  in_tuser;   // [0] req_type
  logic                  out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] payload, [8] abort, [9] flush, [10] active,
                                     // [42:11] generation
  logic                  out_tlast;  // last_byte
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  deframer_scoreboard sb;
  bit in_idle, out_idle;
  int active_items, phase_items, cycles, n_phases;

  serial_frame_receiver_session i_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_output(out_tdata[7:0], out_tlast, out_tdata[8], out_tdata[9], out_tdata[10],
                      out_tdata[42:11]);

  // result-side backpressure
  initial begin : out_stall
    int n;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (rst_n && out_idle && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  function automatic bit pick_link();
    if (sb.probe) return $urandom_range(0, 49) != 0;
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic send_item(bit tick, logic [7:0] b, bit link);
    int n;
    @(negedge clk);
    if (in_idle && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= tick;
    in_tdata  <= {7'd0, link, b};
    do @(posedge clk); while (!in_tready);
    if (sb.en) active_items++;
    phase_items++;
    sb.predict_item(tick, b, link);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain: every owed output seen, then let no-output items in flight retire
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure(cfg_profile_t prof);
    bit          en_v, probe_v;
    logic [15:0] tmo_v, max_v;
    logic [23:0] lease_v;
    en_v = 1'b1;
    probe_v = 1'b0;
    tmo_v = 16'($urandom_range(2, 30));
    lease_v = 24'($urandom_range(5, 60));
    max_v = 16'($urandom_range(8, 30));
    case (prof)
      CFG_PROBE_WIDE: begin
        probe_v = 1'b1;
        lease_v = 24'hFFFFFF;
        max_v = 16'hFFFF;
      end
      CFG_TIGHT: begin
        tmo_v = 16'd0;
        lease_v = 24'd0;
        max_v = 16'd1;
      end
      CFG_OFF: begin
        en_v = 1'b0;
        probe_v = 1'($urandom_range(0, 1));
        tmo_v = 16'($urandom);
        lease_v = 24'($urandom);
        max_v = 16'($urandom_range(1, 65535));
      end
      CFG_SLOW: begin
        tmo_v = 16'hFFFF;
        lease_v = 24'hFFFFFF;
        max_v = 16'($urandom_range(8, 40));
      end
      CFG_WIDE_LEN: begin
        tmo_v = 16'($urandom_range(1, 12));
        lease_v = 24'($urandom_range(3, 20));
        max_v = 16'hFFFF;
      end
      CFG_PROBE_TIGHT: begin
        probe_v = 1'b1;
        tmo_v = 16'd0;
        lease_v = 24'd0;
      end
      CFG_DIRECTED: begin
        tmo_v = 16'd0;
        lease_v = 24'd2;
        max_v = 16'd2;
      end
      default: ;
    endcase
    write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_INDEX)),
              CFG_DATA_W'($urandom));
    write_reg(REG_LINK_PROBE, {23'($urandom), probe_v});
    write_reg(REG_TIMEOUT, {8'($urandom), tmo_v});
    write_reg(REG_LEASE, lease_v);
    write_reg(REG_MAX_LEN, {8'($urandom), max_v});
    write_reg(REG_ENABLED, {23'($urandom), en_v});
    n_phases++;
  endtask

  task automatic send_bytes(logic [7:0] seq[]);
    foreach (seq[i]) send_item(1'b0, seq[i], 1'b1);
  endtask

  // One frame, mostly well formed: optional noise, header, payload with ticks mixed in.
  task automatic send_frame();
    int         len, n, r;
    bit         cut_ok, cut;
    logic [7:0] head;
    cut_ok = (sb.tmo <= 40) || sb.probe;
    if ($urandom_range(0, 3) == 0)
      send_item(1'($urandom_range(0, 1)), 8'($urandom), pick_link());
    r = $urandom_range(0, 9);
    if (r == 0) len = 0;
    else if (r == 1 && cut_ok) len = $urandom_range(0, 65535);
    else if (r == 2 && sb.maxlen < 60) len = sb.maxlen + $urandom_range(1, 4);
    else len = $urandom_range(1, 24);
    if ($urandom_range(0, 1)) head = $urandom_range(0, 1) ? HS_OPEN_CODE : HS_ALT_CODE;
    else head = 8'($urandom);
    cut = cut_ok && (len > 64 || $urandom_range(0, 9) == 0);
    n = cut ? $urandom_range(0, (len < 40) ? len : 40) : len;
    send_item(1'b0, START_MARK, pick_link());
    send_item(1'b0, len[7:0], pick_link());
    send_item(1'b0, len[15:8], pick_link());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom), pick_link());
      send_item(1'b0, (i == 0) ? head : 8'($urandom), pick_link());
    end
    if (cut) begin
      if (sb.probe) send_item(1'b1, 8'($urandom), 1'b0);
      else repeat (sb.tmo + 1) send_item(1'b1, 8'($urandom), pick_link());
    end
  endtask

  initial begin : stimulus
    cfg_profile_t prof;
    int           budget;
    sb = new();
    active_items = 0; phase_items = 0; n_phases = 0;
    in_idle = 1'b1; out_idle = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // disabled after reset: everything is discarded
    send_item(1'b0, START_MARK, 1'b1);
    send_item(1'b1, 8'h5A, 1'b0);
    settle();

    // zero length, alt handshake opens, plain frame passes, oversized drain,
    // zero-timeout abort, lease expiry, renewing handshake with flush
    configure(CFG_DIRECTED);
    send_bytes('{START_MARK, 8'h00, 8'h00});
    send_bytes('{START_MARK, 8'h02, 8'h00, HS_ALT_CODE, 8'hFF});
    send_bytes('{START_MARK, 8'h01, 8'h00, 8'h00});
    send_bytes('{START_MARK, 8'h03, 8'h00, HS_OPEN_CODE, 8'h80, 8'h7F});
    send_bytes('{START_MARK, 8'h02, 8'h00, 8'h05});
    send_item(1'b1, 8'hA5, 1'b1);
    send_item(1'b1, 8'h5A, 1'b1);
    send_bytes('{START_MARK, 8'h02, 8'h00, HS_ALT_CODE, 8'h81});
    settle();

    for (int ph = 0; active_items < ITEM_TARGET; ph++) begin
      if (ph < CFG_DIRECTED) prof = cfg_profile_t'(ph);
      else case ($urandom_range(0, 3))
        0: prof = CFG_SHORT_LEASE;
        1: prof = CFG_PROBE_WIDE;
        2: prof = CFG_WIDE_LEN;
        default: prof = CFG_PROBE_TIGHT;
      endcase
      in_idle  = (active_items < ITEM_TARGET - 250) && ($urandom_range(0, 4) != 0);
      out_idle = (active_items < ITEM_TARGET - 250) && ($urandom_range(0, 4) != 0);
      configure(prof);
      budget = (prof == CFG_OFF) ? 30 : 200;
      phase_items = 0;
      while (phase_items < budget) send_frame();
      settle();
    end

    $display("%0d enabled input transactions over %0d register settings, %0d results checked",
             active_items, n_phases, sb.n_results);
    $display("%0d frames completed, %0d aborted, %0d lease renewals with flush",
             sb.n_last, sb.n_abort, sb.n_flush);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending_outputs.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
